### sv/rar_pkg.sv
// Package: shared constants, operation codes and unit status type for the rational reducer.
`timescale 1ns / 1ps

package rar_pkg;

    localparam int WIDTH_DEF = 16;
    localparam int OP_W      = 2;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    // status reported by an iterative unit to its sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

### sv/rar_if.sv
// Interfaces: request and response valid/ready channels of the rational reducer.
`timescale 1ns / 1ps

interface rar_req_if
    import rar_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         req_type;
    logic signed [WIDTH-1:0] first_num;
    logic [WIDTH-2:0]        first_den;
    logic signed [WIDTH-1:0] second_num;
    logic [WIDTH-2:0]        second_den;

    modport source (
        output valid, req_type, first_num, first_den, second_num, second_den,
        input  ready
    );
    modport sink (
        input  valid, req_type, first_num, first_den, second_num, second_den,
        output ready
    );
endinterface

interface rar_rsp_if
    import rar_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] result_num;
    logic [RES_DEN_W-1:0]        result_den;
    logic                        div_by_zero;

    modport source (
        output valid, result_num, result_den, div_by_zero,
        input  ready
    );
    modport sink (
        input  valid, result_num, result_den, div_by_zero,
        output ready
    );
endinterface

### sv/rational_arith_reduce.sv
// Top level: exact add, subtract, multiply or divide of two fractions, reduced by their gcd.
//
// Usage:
//   req carries one request per transfer: req_type (0 add, 1 subtract, 2 multiply,
//   3 divide) and two fractions first_num/first_den and second_num/second_den.
//   rsp carries one result per request: result_num/result_den in lowest terms with
//   a positive denominator, and div_by_zero set (result 0/1) when the raw
//   denominator is zero. A zero numerator gives 0/1.
// Timing:
//   One request at a time; req.ready is high only while the sequencer is idle.
//   The shared multiplier runs in S_MUL0, S_MUL1 and S_MUL2, S_FORM forms the
//   numerator and S_NORM normalizes signs, then come the binary gcd unit and
//   two passes through the bit-serial divider. Zero cases skip the gcd unit and
//   the divider and go straight from S_NORM to S_DONE.
// Reset:
//   rst_n clears the sequencer, both units and the output valid flag at once.
// Stall:
//   A finished result waits in the output register while the next request is
//   taken; a second result then holds in the sequencer until rsp drains.
`timescale 1ns / 1ps

module rational_arith_reduce
    import rar_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    rar_req_if.sink  req,
    rar_rsp_if.source rsp
);

    localparam int DW = WIDTH - 1;       // operand denominator bits
    localparam int PW = 2 * WIDTH;       // signed product and raw numerator
    localparam int MW = 2 * WIDTH - 1;   // magnitudes fed to gcd and divider

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_FORM = 4'd4;
    localparam logic [3:0] S_NORM = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVN = 4'd7;
    localparam logic [3:0] S_DIVD = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // operands
    logic [OP_W-1:0]         op_reg;
    logic signed [WIDTH-1:0] an_reg, bn_reg;
    logic [DW-1:0]           ad_reg, bd_reg;
    logic signed [WIDTH-1:0] ad_s, bd_s;

    // products and raw fraction
    logic signed [PW-1:0] p0_reg, p1_reg, den_reg, num_reg;
    logic signed [PW-1:0] num_form;

    // normalized magnitudes
    logic [MW-1:0] mag_num_reg, mag_den_reg;
    logic [PW-1:0] num_abs, den_abs;
    logic          neg_reg, err_reg;
    logic [MW-1:0] g_reg, qn_reg, qd_reg;

    // shared multiplier
    logic signed [WIDTH-1:0] mul_a, mul_b;
    logic signed [PW-1:0]    mul_p;

    // iterative units
    logic          gcd_start, div_start;
    unit_stat_t    gcd_stat, div_stat;
    logic [MW-1:0] gcd_g, div_q, div_dividend, div_divisor;

    // output conversion
    logic signed [PW-1:0] res_signed;
    logic signed [63:0]   num_wide;
    logic [63:0]          den_wide;
    logic                 load_out;

    logic signed [RES_NUM_W-1:0] out_num_reg;
    logic [RES_DEN_W-1:0]        out_den_reg;
    logic                        out_err_reg;

    assign ad_s = signed'({1'b0, ad_reg});
    assign bd_s = signed'({1'b0, bd_reg});

    // operand pairs for each multiplier step
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bn_reg;
        case (state_reg)
            S_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_s;
            end
            S_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_s;
            end
            S_MUL2:
            begin
                mul_a = ad_s;
                mul_b = (op_reg == OP_DIV) ? bn_reg : bd_s;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bn_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  num_form = p0_reg + p1_reg;
            OP_SUB:  num_form = p0_reg - p1_reg;
            default: num_form = p0_reg;
        endcase
    end

    assign num_abs = num_reg[PW-1] ? PW'(-num_reg) : PW'(num_reg);
    assign den_abs = den_reg[PW-1] ? PW'(-den_reg) : PW'(den_reg);

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        gcd_start  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE: if (req.valid) state_next = S_MUL0;
            S_MUL0: state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_FORM;
            S_FORM: state_next = S_NORM;
            S_NORM:
            begin
                if (den_reg == '0 || num_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    gcd_start  = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gcd_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVD;
                end
            end
            S_DIVD: if (div_stat.done) state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // first pass divides the numerator, second the denominator
    assign div_dividend = (state_reg == S_GCD) ? mag_num_reg : mag_den_reg;
    assign div_divisor  = (state_reg == S_GCD) ? gcd_g : g_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg <= req.req_type;
                an_reg <= req.first_num;
                ad_reg <= req.first_den;
                bn_reg <= req.second_num;
                bd_reg <= req.second_den;
            end
            S_MUL0: p0_reg  <= mul_p;
            S_MUL1: p1_reg  <= mul_p;
            S_MUL2: den_reg <= mul_p;
            S_FORM: num_reg <= num_form;
            S_NORM:
            begin
                mag_num_reg <= num_abs[MW-1:0];
                mag_den_reg <= den_abs[MW-1:0];
                neg_reg     <= num_reg[PW-1] ^ den_reg[PW-1];
                err_reg     <= (den_reg == '0);
                // zero denominator or zero numerator: result is 0/1
                qn_reg      <= '0;
                qd_reg      <= MW'(1);
            end
            S_GCD:
            begin
                if (gcd_stat.done)
                begin
                    g_reg <= gcd_g;
                end
            end
            S_DIVN:
            begin
                if (div_stat.done)
                begin
                    qn_reg <= div_q;
                end
            end
            S_DIVD:
            begin
                if (div_stat.done)
                begin
                    qd_reg <= div_q;
                end
            end
            default:
            begin
            end
        endcase
    end

    // apply the sign and fit the output fields
    assign res_signed = neg_reg ? PW'(-signed'({1'b0, qn_reg})) : signed'({1'b0, qn_reg});
    assign num_wide   = 64'(res_signed);
    assign den_wide   = 64'(qd_reg);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_num_reg <= num_wide[RES_NUM_W-1:0];
            out_den_reg <= den_wide[RES_DEN_W-1:0];
            out_err_reg <= err_reg;
        end
    end

    // the gcd unit loads its operands at the edge that leaves S_NORM
    rar_gcd #(
        .MW (MW)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a_in  (num_abs[MW-1:0]),
        .b_in  (den_abs[MW-1:0]),
        .stat  (gcd_stat),
        .g     (gcd_g)
    );

    rar_div #(
        .MW (MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_num  = out_num_reg;
    assign rsp.result_den  = out_den_reg;
    assign rsp.div_by_zero = out_err_reg;

endmodule

### sv/rar_gcd.sv
// Binary gcd unit: one shift or subtract step per cycle on two nonzero magnitudes.
`timescale 1ns / 1ps

module rar_gcd
    import rar_pkg::*;
#(
    parameter int MW = 2 * WIDTH_DEF - 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] a_in,
    input  logic [MW-1:0] b_in,
    output unit_stat_t    stat,
    output logic [MW-1:0] g
);

    localparam int KW = $clog2(MW + 1);

    localparam logic [1:0] G_IDLE  = 2'd0;
    localparam logic [1:0] G_RUN   = 2'd1;
    localparam logic [1:0] G_SHIFT = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [MW-1:0] a_reg, a_next;
    logic [MW-1:0] b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic          done;
    logic [MW:0]   diff_ab;
    logic [MW-1:0] diff_ba;

    assign diff_ab = {1'b0, a_reg} - {1'b0, b_reg};
    assign diff_ba = b_reg - a_reg;

    always_comb
    begin
        phase_next = phase_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        done       = 1'b0;
        unique case (phase_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    a_next     = a_in;
                    b_next     = b_in;
                    k_next     = '0;
                    phase_next = G_RUN;
                end
            end
            G_RUN:
            begin
                if (a_reg == b_reg)
                begin
                    phase_next = G_SHIFT;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    // strip a common factor of two
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (diff_ab[MW])
                begin
                    b_next = diff_ba;
                end
                else
                begin
                    a_next = diff_ab[MW-1:0];
                end
            end
            G_SHIFT:
            begin
                // restore the common powers of two
                if (k_reg == '0)
                begin
                    done       = 1'b1;
                    phase_next = G_IDLE;
                end
                else
                begin
                    a_next = a_reg << 1;
                    k_next = k_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= G_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    assign g         = a_reg;
    assign stat.busy = (phase_reg != G_IDLE);
    assign stat.done = done;

endmodule

### sv/rar_div.sv
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module rar_div
    import rar_pkg::*;
#(
    parameter int MW = 2 * WIDTH_DEF - 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] dividend,
    input  logic [MW-1:0] divisor,
    output unit_stat_t    stat,
    output logic [MW-1:0] quotient
);

    localparam int CW = $clog2(MW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0] q_reg, q_next;
    logic [MW-1:0] r_reg, r_next;
    logic [MW-1:0] d_reg, d_next;
    logic [MW:0]   r_shift;
    logic [MW:0]   trial;

    assign r_shift = {r_reg, q_reg[MW-1]};
    assign trial   = r_shift - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(MW);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            // keep the difference when it does not borrow
            if (trial[MW])
            begin
                r_next = r_shift[MW-1:0];
                q_next = {q_reg[MW-2:0], 1'b0};
            end
            else
            begin
                r_next = trial[MW-1:0];
                q_next = {q_reg[MW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
